/* design/fwlt_pkg.sv */
// Shared package for the failure window lockout table.
// Holds table sizing, field widths, operation and register codes, sequencer types
// and the count saturation helper. Depends on nothing.
package fwlt_pkg;

    localparam int TABLE_DEPTH          = 1024;
    localparam int EXTRA_WINDOW_SECONDS = 60;

    localparam int STAMP_W   = 64;
    localparam int UNLOCK_W  = 32;
    localparam int FCNT_W    = 11;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLICIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_WINDOW = 2'd2;

    localparam logic [UNLOCK_W-1:0] UNLOCK_RESET      = 32'd300;
    localparam logic [STAMP_W-1:0]  FAIL_WINDOW_RESET = 64'd900;
    localparam logic [STAMP_W-1:0]  EXTRA_STAMP       = STAMP_W'(EXTRA_WINDOW_SECONDS);
    localparam logic [STAMP_W-1:0]  WINDOW_RESET      =
        STAMP_W'(300 + EXTRA_WINDOW_SECONDS);
    localparam logic [CNT_W-1:0]    DEPTH_COUNT       = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_MIN_SCAN,
        ST_REC_WRITE,
        ST_MAX_SCAN,
        ST_CNT_SCAN,
        ST_FIN,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_CLR,
        DP_MAX,
        DP_MIN,
        DP_CNT,
        DP_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [ADDR_W-1:0] pidx;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } dp_ctrl_t;

    function automatic logic [FCNT_W-1:0] sat_count(input logic [CNT_W-1:0] hits);
        logic [CNT_W+FCNT_W-1:0] wide;
        logic [CNT_W+FCNT_W-1:0] lim;
        wide = (CNT_W + FCNT_W)'(hits);
        lim  = (CNT_W + FCNT_W)'({FCNT_W{1'b1}});
        if (wide > lim)
        begin
            sat_count = {FCNT_W{1'b1}};
        end
        else
        begin
            sat_count = wide[FCNT_W-1:0];
        end
    endfunction

endpackage

/* design/fwlt_cfg.sv */
// Configuration register file for the failure window lockout table.
// Holds the unlock time and window settings and keeps the effective window registered.
// Depends on fwlt_pkg.
module fwlt_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [fwlt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fwlt_pkg::STAMP_W-1:0]      cfg_data,
    output logic [fwlt_pkg::UNLOCK_W-1:0]     unlock,
    output logic [fwlt_pkg::STAMP_W-1:0]      window
);

    logic [fwlt_pkg::UNLOCK_W-1:0] unlock_reg;
    logic [fwlt_pkg::UNLOCK_W-1:0] unlock_next;
    logic                          explicit_reg;
    logic                          explicit_next;
    logic [fwlt_pkg::STAMP_W-1:0]  fwin_reg;
    logic [fwlt_pkg::STAMP_W-1:0]  fwin_next;
    logic [fwlt_pkg::STAMP_W-1:0]  window_reg;
    logic [fwlt_pkg::STAMP_W-1:0]  window_next;

    always_comb
    begin
        unlock_next   = unlock_reg;
        explicit_next = explicit_reg;
        fwin_next     = fwin_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                fwlt_pkg::CFG_UNLOCK:      unlock_next   = cfg_data[fwlt_pkg::UNLOCK_W-1:0];
                fwlt_pkg::CFG_EXPLICIT:    explicit_next = cfg_data[0];
                fwlt_pkg::CFG_FAIL_WINDOW: fwin_next     = cfg_data;
                default:                   ;
            endcase
        end
        // The window is precomputed so the scan never sees the extra add.
        if (explicit_next)
        begin
            window_next = fwin_next;
        end
        else
        begin
            window_next = fwlt_pkg::STAMP_W'(unlock_next) + fwlt_pkg::EXTRA_STAMP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlock_reg   <= fwlt_pkg::UNLOCK_RESET;
            explicit_reg <= 1'b0;
            fwin_reg     <= fwlt_pkg::FAIL_WINDOW_RESET;
            window_reg   <= fwlt_pkg::WINDOW_RESET;
        end
        else
        begin
            unlock_reg   <= unlock_next;
            explicit_reg <= explicit_next;
            fwin_reg     <= fwin_next;
            window_reg   <= window_next;
        end
    end

    assign unlock = unlock_reg;
    assign window = window_reg;

endmodule

/* design/fwlt_alu.sv */
// Shared 64-bit add/subtract unit with a trailing less-than compare.
// Used for maximum, minimum, window and unlock checks in turn.
// Depends on fwlt_pkg.
module fwlt_alu (
    input  logic [fwlt_pkg::STAMP_W-1:0] a,
    input  logic [fwlt_pkg::STAMP_W-1:0] b,
    input  logic [fwlt_pkg::STAMP_W-1:0] c,
    input  logic                         sub,
    output logic                         borrow,
    output logic                         lt
);

    logic [fwlt_pkg::STAMP_W:0]   sum;
    logic [fwlt_pkg::STAMP_W-1:0] b_in;

    always_comb
    begin
        b_in   = sub ? ~b : b;
        sum    = {1'b0, a} + {1'b0, b_in} + (fwlt_pkg::STAMP_W + 1)'(sub);
        borrow = sub ? !sum[fwlt_pkg::STAMP_W] : sum[fwlt_pkg::STAMP_W];
        lt     = (sum[fwlt_pkg::STAMP_W-1:0] < c);
    end

endmodule

/* design/fwlt_scan.sv */
// Timestamp memory and scan datapath of the failure window lockout table.
// Holds the stamp memory, the accumulators and the shared arithmetic unit.
// Depends on fwlt_pkg and fwlt_alu.
module fwlt_scan (
    input  logic                            clk,
    input  fwlt_pkg::dp_ctrl_t              dp,
    input  logic [fwlt_pkg::STAMP_W-1:0]    now,
    input  logic [fwlt_pkg::UNLOCK_W-1:0]   unlock,
    input  logic [fwlt_pkg::STAMP_W-1:0]    window,
    output logic [fwlt_pkg::ADDR_W-1:0]     slot,
    output logic [fwlt_pkg::FCNT_W-1:0]     res_count,
    output logic [fwlt_pkg::STAMP_W-1:0]    res_time
);

    logic [fwlt_pkg::STAMP_W-1:0] stamp_mem [fwlt_pkg::TABLE_DEPTH];
    logic [fwlt_pkg::STAMP_W-1:0] rdata_reg;
    logic [fwlt_pkg::STAMP_W-1:0] acc_reg;
    logic [fwlt_pkg::CNT_W-1:0]   hits_reg;
    logic [fwlt_pkg::ADDR_W-1:0]  slot_reg;

    logic [fwlt_pkg::STAMP_W-1:0] alu_a;
    logic [fwlt_pkg::STAMP_W-1:0] alu_b;
    logic [fwlt_pkg::STAMP_W-1:0] alu_c;
    logic                         alu_sub;
    logic                         alu_borrow;
    logic                         alu_lt;
    logic                         locked;

    always_ff @(posedge clk)
    begin
        if (dp.wr_en)
        begin
            stamp_mem[dp.wr_addr] <= now;
        end
        if (dp.rd_en)
        begin
            rdata_reg <= stamp_mem[dp.rd_addr];
        end
    end

    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = rdata_reg;
        alu_c   = window;
        alu_sub = 1'b1;
        unique case (dp.op)
            fwlt_pkg::DP_MIN:
            begin
                alu_a = rdata_reg;
                alu_b = acc_reg;
            end
            fwlt_pkg::DP_FIN:
            begin
                alu_b   = fwlt_pkg::STAMP_W'(unlock);
                alu_c   = now;
                alu_sub = 1'b0;
            end
            default: ;
        endcase
    end

    fwlt_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .c      (alu_c),
        .sub    (alu_sub),
        .borrow (alu_borrow),
        .lt     (alu_lt)
    );

    always_ff @(posedge clk)
    begin
        unique case (dp.op)
            fwlt_pkg::DP_CLR:
            begin
                acc_reg  <= '0;
                hits_reg <= '0;
            end
            fwlt_pkg::DP_MAX:
            begin
                if (alu_borrow)
                begin
                    acc_reg <= rdata_reg;
                end
            end
            fwlt_pkg::DP_MIN:
            begin
                // The first entry seeds the search; later ones replace it only when strictly older.
                if ((dp.pidx == '0) || alu_borrow)
                begin
                    acc_reg  <= rdata_reg;
                    slot_reg <= dp.pidx;
                end
            end
            fwlt_pkg::DP_CNT:
            begin
                if (alu_lt)
                begin
                    hits_reg <= hits_reg + fwlt_pkg::CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign locked    = (dp.op == fwlt_pkg::DP_FIN) && !alu_lt;
    assign res_count = locked ? fwlt_pkg::sat_count(hits_reg) : '0;
    assign res_time  = locked ? acc_reg : '0;
    assign slot      = slot_reg;

endmodule

/* design/fwlt_ctrl.sv */
// Sequencer of the failure window lockout table.
// Runs the scan passes over the table, keeps the entry count and hands results out.
// Depends on fwlt_pkg.
module fwlt_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [fwlt_pkg::OP_W-1:0]     operation,
    input  logic                          slot_free,
    input  logic [fwlt_pkg::ADDR_W-1:0]   slot,
    output logic                          in_ready,
    output fwlt_pkg::dp_ctrl_t            dp,
    output logic                          out_load,
    output logic                          out_query
);

    fwlt_pkg::state_t            state_reg;
    fwlt_pkg::state_t            state_next;
    logic [fwlt_pkg::CNT_W-1:0]  count_reg;
    logic [fwlt_pkg::CNT_W-1:0]  count_next;
    logic [fwlt_pkg::CNT_W-1:0]  issue_reg;
    logic [fwlt_pkg::CNT_W-1:0]  issue_next;
    logic                        pv_reg;
    logic                        pv_next;
    logic [fwlt_pkg::ADDR_W-1:0] pidx_reg;
    logic [fwlt_pkg::ADDR_W-1:0] pidx_next;
    logic                        issuing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwlt_pkg::ST_IDLE;
            count_reg <= '0;
            issue_reg <= '0;
            pv_reg    <= 1'b0;
            pidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pv_reg    <= pv_next;
            pidx_reg  <= pidx_next;
        end
    end

    assign issuing = (issue_reg < count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        issue_next = issue_reg;
        pv_next    = 1'b0;
        pidx_next  = pidx_reg;
        dp         = '0;
        dp.op      = fwlt_pkg::DP_NONE;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        out_query  = 1'b0;

        unique case (state_reg)
            fwlt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (operation)
                        fwlt_pkg::OP_RECORD:
                        begin
                            if (count_reg == fwlt_pkg::DEPTH_COUNT)
                            begin
                                state_next = fwlt_pkg::ST_MIN_SCAN;
                            end
                            else
                            begin
                                state_next = fwlt_pkg::ST_APPEND;
                            end
                        end
                        fwlt_pkg::OP_QUERY:
                        begin
                            dp.op = fwlt_pkg::DP_CLR;
                            if (count_reg == '0)
                            begin
                                state_next = fwlt_pkg::ST_FIN;
                            end
                            else
                            begin
                                state_next = fwlt_pkg::ST_MAX_SCAN;
                            end
                        end
                        fwlt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = fwlt_pkg::ST_RESULT;
                        end
                        default:
                        begin
                            state_next = fwlt_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            fwlt_pkg::ST_APPEND:
            begin
                dp.wr_en   = 1'b1;
                dp.wr_addr = count_reg[fwlt_pkg::ADDR_W-1:0];
                count_next = count_reg + fwlt_pkg::CNT_W'(1);
                state_next = fwlt_pkg::ST_RESULT;
            end
            fwlt_pkg::ST_MIN_SCAN, fwlt_pkg::ST_MAX_SCAN, fwlt_pkg::ST_CNT_SCAN:
            begin
                // One read is issued per cycle; its data is processed in the following cycle.
                dp.rd_en   = issuing;
                dp.rd_addr = issue_reg[fwlt_pkg::ADDR_W-1:0];
                pv_next    = issuing;
                if (issuing)
                begin
                    issue_next = issue_reg + fwlt_pkg::CNT_W'(1);
                    pidx_next  = issue_reg[fwlt_pkg::ADDR_W-1:0];
                end
                dp.pidx = pidx_reg;
                if (pv_reg)
                begin
                    unique case (state_reg)
                        fwlt_pkg::ST_MIN_SCAN: dp.op = fwlt_pkg::DP_MIN;
                        fwlt_pkg::ST_MAX_SCAN: dp.op = fwlt_pkg::DP_MAX;
                        default:               dp.op = fwlt_pkg::DP_CNT;
                    endcase
                end
                if (!issuing && !pv_reg)
                begin
                    issue_next = '0;
                    unique case (state_reg)
                        fwlt_pkg::ST_MIN_SCAN: state_next = fwlt_pkg::ST_REC_WRITE;
                        fwlt_pkg::ST_MAX_SCAN: state_next = fwlt_pkg::ST_CNT_SCAN;
                        default:               state_next = fwlt_pkg::ST_FIN;
                    endcase
                end
            end
            fwlt_pkg::ST_REC_WRITE:
            begin
                dp.wr_en   = 1'b1;
                dp.wr_addr = slot;
                state_next = fwlt_pkg::ST_RESULT;
            end
            fwlt_pkg::ST_FIN:
            begin
                dp.op = fwlt_pkg::DP_FIN;
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_query  = 1'b1;
                    state_next = fwlt_pkg::ST_IDLE;
                end
            end
            fwlt_pkg::ST_RESULT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = fwlt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fwlt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/failure_window_lockout_table.sv */
// Top level of the failure window lockout table.
// Joins the configuration registers, the sequencer and the scan datapath,
// and holds the output register.
// Depends on fwlt_pkg, fwlt_cfg, fwlt_ctrl and fwlt_scan.
//
// Usage:
// Each input transaction carries an operation (record, query or clear) and the current time.
// Exactly one output transaction follows each input transaction, in order.
// The configuration channel is always ready and should only be written while the block is idle.
// A clear and an unused code go straight to the result, and a record into a table that is not
// full first appends its time. A record into a full table first scans all TABLE_DEPTH entries
// for the oldest one and then overwrites it. A query makes two passes over the n stored entries,
// one for the latest time and one for the count; an empty table skips both passes. The single
// read port of the stamp memory delivers one entry per cycle to the shared arithmetic unit.
// One item is worked on at a time; in_ready is low from acceptance until its result is loaded.
// A finished result waits in the output register; while the receiver stalls, the next item can
// still be accepted, but its own result waits until the register has been emptied.
// Reset empties the table and restores the configuration defaults; no clearing pass is needed.
module failure_window_lockout_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fwlt_pkg::OP_W-1:0]          operation,
    input  logic [fwlt_pkg::STAMP_W-1:0]       now,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fwlt_pkg::FCNT_W-1:0]        fail_count,
    output logic [fwlt_pkg::STAMP_W-1:0]       latest_fail,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fwlt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fwlt_pkg::STAMP_W-1:0]       cfg_data
);

    logic [fwlt_pkg::UNLOCK_W-1:0] unlock;
    logic [fwlt_pkg::STAMP_W-1:0]  window;
    fwlt_pkg::dp_ctrl_t            dp;
    logic [fwlt_pkg::ADDR_W-1:0]   slot;
    logic [fwlt_pkg::FCNT_W-1:0]   res_count;
    logic [fwlt_pkg::STAMP_W-1:0]  res_time;
    logic                          out_load;
    logic                          out_query;
    logic                          slot_free;

    logic [fwlt_pkg::STAMP_W-1:0]  now_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [fwlt_pkg::FCNT_W-1:0]   fail_count_reg;
    logic [fwlt_pkg::STAMP_W-1:0]  latest_fail_reg;

    assign cfg_ready = 1'b1;

    fwlt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .unlock    (unlock),
        .window    (window)
    );

    fwlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .slot_free (slot_free),
        .slot      (slot),
        .in_ready  (in_ready),
        .dp        (dp),
        .out_load  (out_load),
        .out_query (out_query)
    );

    fwlt_scan u_scan (
        .clk       (clk),
        .dp        (dp),
        .now       (now_reg),
        .unlock    (unlock),
        .window    (window),
        .slot      (slot),
        .res_count (res_count),
        .res_time  (res_time)
    );

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg <= now;
        end
        if (out_load)
        begin
            fail_count_reg  <= out_query ? res_count : '0;
            latest_fail_reg <= out_query ? res_time : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign fail_count  = fail_count_reg;
    assign latest_fail = latest_fail_reg;

endmodule

/* design/fwlt_checker.sv */
// Port-level checker for the failure window lockout table, with its bind statement.
// Depends on fwlt_pkg and on the ports of failure_window_lockout_table.
module fwlt_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [fwlt_pkg::FCNT_W-1:0]   fail_count,
    input  logic [fwlt_pkg::STAMP_W-1:0]  latest_fail
);

    // A stalled result must hold its value until the transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fail_count) && $stable(latest_fail))
    else $error("Stalled result changed before its transaction completed.");

    // Every operation keeps the block busy in the cycle after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("Block was ready again directly after accepting a transaction.");

    // A new result only appears while an item is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("Result appeared without an item in progress.");

    // The count can never exceed the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(fail_count) <= fwlt_pkg::TABLE_DEPTH)
    else $error("Failure count exceeds the table depth.");

endmodule

bind failure_window_lockout_table fwlt_checker u_fwlt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fail_count  (fail_count),
    .latest_fail (latest_fail)
);
